### hw/rtl/tw_cache_pkg.sv
`default_nettype none

package tw_cache_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned SIB_W      = 4;

  // Parameter defaults
  localparam int unsigned MAX_SETS_DEF         = 512;
  localparam int unsigned LINE_OFFSET_BITS_DEF = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPLACE_MODE   = 1'b0,
    REG_SET_INDEX_BITS = 1'b1
  } cfg_reg_e;

  // Replacement order
  typedef enum logic {
    MODE_LRU  = 1'b0,
    MODE_FIFO = 1'b1
  } replace_mode_e;

  localparam logic [SIB_W-1:0] SIB_RESET = SIB_W'(9);

  // Per-set replacement row: victim way and one valid bit per way
  typedef struct packed {
    logic       vic;
    logic [1:0] vld;
  } set_state_t;

  localparam set_state_t SET_STATE_RESET = '{vic: 1'b1, vld: 2'b00};

endpackage

`default_nettype wire

### hw/rtl/two_way_cache_lookup_top.sv
`default_nettype none
// Channel   Signals                                  Transfer condition
// -------   --------------------------------------   ------------------------------
// access    start_i, busy_o, address_i[31:0]         start_i && !busy_o at clk_i edge
// result    done_o, hit_o, way_o                     done_o high for one cycle
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i[3:0]    cfg_we_i at clk_i edge
//
// For an access, the set row is read from the tag and state memories in the accept
// cycle, compared, updated and written back in the next. The result strobes the
// cycle after that, while the next access may already be accepted. busy_o is high
// while the row is compared and written back, so a new access is not taken until
// the row is written back. After reset the block clears the state memory, one set
// per cycle, through all MAX_SETS sets with busy_o high. Results cannot be stalled.

module two_way_cache_lookup_top
  import tw_cache_pkg::*;
#(
  parameter int unsigned MAX_SETS         = MAX_SETS_DEF,
  parameter int unsigned LINE_OFFSET_BITS = LINE_OFFSET_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [ADDR_W-1:0]     address_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic                       way_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned LINE_W = ADDR_W - LINE_OFFSET_BITS;
  localparam logic [SET_W-1:0] SET_MAX_MASK = SET_W'(MAX_SETS - 1);
  localparam logic [SET_W-1:0] CLR_LAST     = SET_W'(MAX_SETS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e                state_q;
  logic [SET_W-1:0]      clr_q;
  logic                  done_q, hit_q, way_q;
  replace_mode_e         mode_q;
  logic [SIB_W-1:0]      sib_q;

  logic [LINE_W-1:0]     line_q;
  logic [SET_W-1:0]      set_q;

  // Memories: tags indexed by {set, way}, replacement state indexed by set
  logic [LINE_W-1:0]     tag_mem [2*MAX_SETS];
  set_state_t            st_mem  [MAX_SETS];
  logic [LINE_W-1:0]     tag0_rd_q, tag1_rd_q;
  set_state_t            st_rd_q;

  logic                  accept;
  logic [LINE_W-1:0]     in_line;
  logic [SET_W-1:0]      set_mask;
  logic [SET_W-1:0]      in_set;

  logic                  hit0, hit1, lk_hit, lk_way;
  set_state_t            lk_state;

  logic                  st_we;
  logic [SET_W-1:0]      st_wa;
  set_state_t            st_wd;
  logic                  tag_we;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign way_o  = way_q;

  // Set index: low set_index_bits of the line address, capped at the memory depth
  assign in_line = address_i[ADDR_W-1:LINE_OFFSET_BITS];
  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sib_q)) && SET_MAX_MASK[i];
    end
  end
  assign in_set = in_line[SET_W-1:0] & set_mask;

  // Compare both ways; way 0 wins a double match
  assign hit0   = st_rd_q.vld[0] && (tag0_rd_q == line_q);
  assign hit1   = st_rd_q.vld[1] && (tag1_rd_q == line_q);
  assign lk_hit = hit0 || hit1;
  assign lk_way = hit0 ? 1'b0 : (hit1 ? 1'b1 : st_rd_q.vic);

  always_comb begin
    lk_state = st_rd_q;
    if (lk_hit) begin
      if (mode_q == MODE_LRU) begin
        lk_state.vic = ~lk_way;
      end
    end else begin
      lk_state.vic         = ~lk_way;
      lk_state.vld[lk_way] = 1'b1;
    end
  end

  // Write-back port: clearing sweep or the row update of a lookup
  always_comb begin
    st_we  = 1'b0;
    st_wa  = set_q;
    st_wd  = lk_state;
    tag_we = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        st_we = 1'b1;
        st_wa = clr_q;
        st_wd = SET_STATE_RESET;
      end
      ST_LOOKUP: begin
        st_we  = 1'b1;
        tag_we = !lk_hit;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag0_rd_q <= tag_mem[{in_set, 1'b0}];
      tag1_rd_q <= tag_mem[{in_set, 1'b1}];
      st_rd_q   <= st_mem[in_set];
    end
    if (tag_we) begin
      tag_mem[{set_q, lk_way}] <= line_q;
    end
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
  end

  // Hold the access while it is looked up
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= in_line;
      set_q  <= in_set;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LRU;
      sib_q  <= SIB_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REPLACE_MODE:   mode_q <= replace_mode_e'(cfg_wdata_i[0]);
        REG_SET_INDEX_BITS: sib_q  <= cfg_wdata_i[SIB_W-1:0];
        default:            sib_q  <= sib_q;
      endcase
    end
  end

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
      way_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == CLR_LAST) begin
            clr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + SET_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          done_q  <= 1'b1;
          hit_q   <= lk_hit;
          way_q   <= lk_way;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A result follows only a lookup cycle
  a_done_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_LOOKUP))
    else $error("result strobe without a lookup");

  // Every lookup delivers exactly one result
  a_lookup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (done_o && state_q == ST_IDLE))
    else $error("lookup did not deliver its result");

  // A line never sits valid in both ways of one set
  a_no_double_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> !(hit0 && hit1))
    else $error("line present in both ways");

  // The clearing counter moves only during the sweep
  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |-> (clr_q == '0))
    else $error("clear counter active outside the sweep");

endmodule

`default_nettype wire
